// File: rtl/core/pmc_pkg.sv
// Package for the per-pixel max/mean composite unit.
// Holds payload structs, store entry layout, divider stage type and step function.
// No dependencies.
package pmc_pkg;

  localparam int unsigned IDX_W       = 12;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned ACC_W       = 24;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned FRAC_W      = 8;
  localparam int unsigned DIV_W       = ACC_W + FRAC_W;
  localparam int unsigned DIV_BITS    = 2;
  localparam int unsigned DIV_STEPS   = DIV_W / DIV_BITS;
  localparam int unsigned PADDR_W     = 4;
  localparam int unsigned PDATA_W     = 32;

  // register indexes, paddr[3:2]
  localparam logic [1:0] REG_MODE       = 2'd0;
  localparam logic [1:0] REG_VALID_LOW  = 2'd1;
  localparam logic [1:0] REG_VALID_HIGH = 2'd2;

  typedef struct packed {
    logic [IDX_W-1:0]              pixel_index;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first_image;
    logic                          last_image;
  } pmc_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_index;
    logic signed [ACC_W-1:0] composite;
    logic [CNT_W-1:0]        valid_count;
  } pmc_out_t;

  // one entry of the pixel store
  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic [CNT_W-1:0]        cnt;
  } pmc_entry_t;

  // one stage of the restoring divider
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
    logic             neg;
    logic [CNT_W-1:0] den;
    logic [CNT_W-1:0] rem;
    logic [DIV_W-1:0] nq;   // numerator bits shift out, quotient bits shift in
  } div_stage_t;

  // DIV_BITS restoring steps on a narrow remainder
  function automatic div_stage_t div_step(div_stage_t s);
    div_stage_t   r;
    logic [CNT_W:0] part;
    r = s;
    for (int i = 0; i < DIV_BITS; i++) begin
      part = {r.rem, r.nq[DIV_W-1]};
      r.nq = {r.nq[DIV_W-2:0], 1'b0};
      if (part >= {1'b0, r.den}) begin
        part    = part - {1'b0, r.den};
        r.nq[0] = 1'b1;
      end
      r.rem = part[CNT_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/pmc_store.sv
// Pixel store: accumulator and count per pixel, one write and one read port.
// Read data is registered. Depends on pmc_pkg.
module pmc_store #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output pmc_pkg::pmc_entry_t rd_data,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  pmc_pkg::pmc_entry_t wr_data
);
  import pmc_pkg::*;

  pmc_entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/pmc_div.sv
// Pipelined restoring divider for the composite (mean, or divisor 1), DIV_BITS quotient bits a stage,
// followed by sign restore, 24-bit clamp and the output register. Depends on pmc_pkg.
module pmc_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  pmc_pkg::div_stage_t req,
  output logic                res_valid,
  input  logic                res_ready,
  output pmc_pkg::pmc_out_t   res
);
  import pmc_pkg::*;

  localparam logic signed [DIV_W:0] ACC_MAX = (DIV_W+1)'((1 << (ACC_W-1)) - 1);
  localparam logic signed [DIV_W:0] ACC_MIN = -(DIV_W+1)'(1 << (ACC_W-1));

  div_stage_t             st [DIV_STEPS+1];
  logic [DIV_STEPS:0]     st_v;
  logic [DIV_STEPS:0]     go;
  logic                   out_go;
  logic signed [DIV_W:0]  q_abs;
  logic signed [DIV_W:0]  q_sgn;
  logic signed [ACC_W-1:0] q_clamp;

  // stall chain: a stage moves when it is empty or the next one moves
  always_comb begin
    out_go        = !res_valid || res_ready;
    go[DIV_STEPS] = !st_v[DIV_STEPS] || out_go;
    for (int k = DIV_STEPS - 1; k >= 0; k--) begin
      go[k] = !st_v[k] || go[k+1];
    end
  end

  assign req_ready = go[0];

  // stage valid bits and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      st_v      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (go[0]) st_v[0] <= req_valid;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        if (go[k]) st_v[k] <= st_v[k-1];
      end
      if (out_go) res_valid <= st_v[DIV_STEPS];
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (go[0]) st[0] <= req;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      if (go[k]) st[k] <= div_step(st[k-1]);
    end
  end

  // sign restore and clamp to the 24-bit signed range
  always_comb begin
    q_abs = $signed({1'b0, st[DIV_STEPS].nq});
    q_sgn = st[DIV_STEPS].neg ? -q_abs : q_abs;
    if (q_sgn > ACC_MAX)      q_clamp = ACC_MAX[ACC_W-1:0];
    else if (q_sgn < ACC_MIN) q_clamp = ACC_MIN[ACC_W-1:0];
    else                      q_clamp = q_sgn[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (out_go) begin
      res.out_index   <= st[DIV_STEPS].idx;
      res.composite   <= q_clamp;
      res.valid_count <= st[DIV_STEPS].cnt;
    end
  end

endmodule

// File: rtl/core/per_pixel_max_or_mean_composite_unit.sv
// Per-pixel max/mean composite unit: read-modify-write on the pixel store, then a divider.
// Throughput: one pixel per cycle unless the divider back-pressures a last-image pixel; a result passes
// the store read at the accept edge, 1 divider input register, DIV_STEPS=16 divider stages and the
// output register.
// Back-to-back hits on one pixel are served by forwarding the last store write.
// Reset (rst, synchronous) clears pipeline valids and sets mode=0, range [-32768, 32767];
// the pixel store is not cleared, a pixel is opened by first_image. Depends on pmc_pkg.
module per_pixel_max_or_mean_composite_unit #(
  parameter int unsigned TILE_PIXELS = 4096,
  parameter int unsigned MAX_IMAGES  = 255
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pix_valid,
  output logic                              pix_ready,
  input  pmc_pkg::pmc_in_t                  pix,
  output logic                              res_valid,
  input  logic                              res_ready,
  output pmc_pkg::pmc_out_t                 res,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pmc_pkg::PADDR_W-1:0]       paddr,
  input  logic [pmc_pkg::PDATA_W-1:0]       pwdata,
  output logic [pmc_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);
  import pmc_pkg::*;

  localparam int unsigned DEPTH  = (TILE_PIXELS < (1 << IDX_W)) ? TILE_PIXELS : (1 << IDX_W);
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LIMIT  = (MAX_IMAGES < 255) ? MAX_IMAGES : 255;
  localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(LIMIT);
  localparam logic signed [ACC_W:0] ACC_MAX = (ACC_W+1)'((1 << (ACC_W-1)) - 1);
  localparam logic signed [ACC_W:0] ACC_MIN = -(ACC_W+1)'(1 << (ACC_W-1));

  // configuration registers
  logic                          mode;
  logic signed [SAMPLE_BITS-1:0] valid_low;
  logic signed [SAMPLE_BITS-1:0] valid_high;

  // update stage
  logic                s1_v;
  pmc_in_t             s1;
  logic                s1_adv;
  logic                pix_take;
  pmc_entry_t          rd_data;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  pmc_entry_t          wr_data;
  logic                last_seen;
  logic [ADDR_W-1:0]   last_addr;
  pmc_entry_t          last_data;

  logic                    in_tile;
  logic                    emit;
  pmc_entry_t              base;
  pmc_entry_t              upd;
  logic                    s_ok;
  logic signed [ACC_W-1:0] s_ext;
  logic signed [ACC_W:0]   sum;
  logic [ACC_W-1:0]        mag;

  div_stage_t              req;
  logic                    req_ready;

  // APB register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b0;
      valid_low  <= -16'sd32768;
      valid_high <= 16'sd32767;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_MODE:       mode       <= pwdata[0];
        REG_VALID_LOW:  valid_low  <= pwdata[SAMPLE_BITS-1:0];
        REG_VALID_HIGH: valid_high <= pwdata[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:       prdata = {{(PDATA_W-1){1'b0}}, mode};
      REG_VALID_LOW:  prdata = PDATA_W'(valid_low);
      REG_VALID_HIGH: prdata = PDATA_W'(valid_high);
      default:        prdata = '0;
    endcase
  end

  // pixel transaction: read issued on accept, item held in s1
  assign pix_ready = !s1_v || s1_adv;
  assign pix_take  = pix_valid && pix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (pix_ready) begin
      s1_v <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_take) s1 <= pix;
  end

  pmc_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .rd_en   (pix_take),
    .rd_addr (pix.pixel_index[ADDR_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // last write kept for forwarding to a read that raced it
  always_ff @(posedge clk) begin
    if (rst) begin
      last_seen <= 1'b0;
    end else if (wr_en) begin
      last_seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_addr <= wr_addr;
      last_data <= wr_data;
    end
  end

  // accumulate: max or saturating sum, valid count, held invalid sample
  always_comb begin
    in_tile = 32'(s1.pixel_index) < 32'(TILE_PIXELS);
    emit    = s1.last_image && in_tile;
    if (s1.first_image) begin
      base = '0;
    end else if (last_seen && (last_addr == s1.pixel_index[ADDR_W-1:0])) begin
      base = last_data;
    end else begin
      base = rd_data;
    end
    s_ext = ACC_W'(s1.sample);
    s_ok  = (s1.sample >= valid_low) && (s1.sample <= valid_high);
    sum   = (ACC_W+1)'(base.acc) + (ACC_W+1)'(s_ext);
    upd   = base;
    if (s_ok) begin
      if (base.cnt == '0) begin
        upd.acc = s_ext;
        upd.cnt = CNT_W'(1);
      end else if (base.cnt < COUNT_LIMIT) begin
        if (mode) begin
          if (sum > ACC_MAX)      upd.acc = ACC_MAX[ACC_W-1:0];
          else if (sum < ACC_MIN) upd.acc = ACC_MIN[ACC_W-1:0];
          else                    upd.acc = sum[ACC_W-1:0];
        end else if (s_ext > base.acc) begin
          upd.acc = s_ext;
        end
        upd.cnt = base.cnt + CNT_W'(1);
      end
    end else if (base.cnt == '0) begin
      upd.acc = s_ext;
    end
  end

  assign s1_adv  = s1_v && (!emit || req_ready);
  assign wr_en   = s1_adv && in_tile;
  assign wr_addr = s1.pixel_index[ADDR_W-1:0];
  assign wr_data = upd;

  // divider request: |acc| * 256 over count, or over 1 for max mode and empty pixels
  always_comb begin
    mag     = upd.acc[ACC_W-1] ? (~upd.acc + ACC_W'(1)) : upd.acc;
    req.idx = s1.pixel_index;
    req.cnt = upd.cnt;
    req.neg = upd.acc[ACC_W-1];
    req.den = (mode && (upd.cnt != '0)) ? upd.cnt : CNT_W'(1);
    req.rem = '0;
    req.nq  = {mag, {FRAC_W{1'b0}}};
  end

  pmc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s1_v && emit),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

// File: verif/per_pixel_max_or_mean_composite_unit_tb.sv
// Testbench for the per-pixel max/mean composite unit: directed and random pixel stacks,
// an in-bench composite predictor and an in-order result scoreboard.
// Depends on pmc_pkg and the per_pixel_max_or_mean_composite_unit RTL.
`timescale 1ns / 1ps

module per_pixel_max_or_mean_composite_unit_tb;
  import pmc_pkg::*;

  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst;
  logic pix_valid;
  logic pix_ready;
  pmc_in_t pix;
  logic res_valid;
  logic res_ready;
  pmc_out_t res;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  per_pixel_max_or_mean_composite_unit dut (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_ready(pix_ready), .pix(pix),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic                    avg_mode;
  logic signed [15:0]      range_lo, range_hi;
  logic signed [ACC_W-1:0] acc_mem [4096];
  logic [CNT_W-1:0]        cnt_mem [4096];

  pmc_in_t  pixel_queue[$];
  pmc_out_t composite_queue[$];
  int       mismatches;
  bit       quiet_tail;   // no idling near the end
  bit       hold_off;     // long receiver stall
  int       send_gap, recv_gap;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [ACC_W-1:0] sat24(longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[ACC_W-1:0];
  endfunction

  // append one pixel transaction to the driver queue
  task automatic queue_pixel(input pmc_in_t p);
    pixel_queue = {pixel_queue, p};
  endtask

  // update the pixel store and predict the composite for one accepted pixel
  task automatic predict_composite(input pmc_in_t p);
    longint   acc, comp, s;
    int       cnt;
    pmc_out_t r;
    s = p.sample;
    if (p.first_image) begin
      acc = 0;
      cnt = 0;
    end else begin
      acc = acc_mem[p.pixel_index];
      cnt = cnt_mem[p.pixel_index];
    end
    if (s >= range_lo && s <= range_hi) begin
      if (cnt == 0) begin
        acc = s;
        cnt = 1;
      end else if (cnt < 255) begin
        if (avg_mode) acc = sat24(acc + s);
        else if (s > acc) acc = s;
        cnt++;
      end
    end else if (cnt == 0) begin
      acc = s;
    end
    acc_mem[p.pixel_index] = sat24(acc);
    cnt_mem[p.pixel_index] = CNT_W'(cnt);
    if (p.last_image) begin
      if (avg_mode && cnt > 0) comp = (acc * 256) / cnt;
      else comp = acc * 256;
      r.out_index   = p.pixel_index;
      r.composite   = sat24(comp);
      r.valid_count = CNT_W'(cnt);
      composite_queue = {composite_queue, r};
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
      send_gap  <= 0;
    end else if (!pix_valid || pix_ready) begin
      if (pix_valid) predict_composite(pix);
      if (send_gap > 0) begin
        send_gap  <= send_gap - 1;
        pix_valid <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        pix       <= pixel_queue.pop_front();
        pix_valid <= 1'b1;
        if (!quiet_tail && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 5);
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (res_valid && res_ready) begin
        if (composite_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected composite idx=%0d", res.out_index);
        end else begin
          pmc_out_t e;
          e = composite_queue.pop_front();
          if (e !== res) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp idx=%0d comp=%0d cnt=%0d, got idx=%0d comp=%0d cnt=%0d",
                       e.out_index, e.composite, e.valid_count,
                       res.out_index, res.composite, res.valid_count);
          end
        end
      end
      if (hold_off) begin
        res_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap  <= recv_gap - 1;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
        if (!quiet_tail && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 5);
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_MODE:      avg_mode = val[0];
      REG_VALID_LOW: range_lo = val[15:0];
      default:       range_hi = val[15:0];
    endcase
  endtask

  task automatic drain();
    while (pixel_queue.size() > 0 || pix_valid || composite_queue.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic pmc_in_t make_pixel(int idx, int s, bit f, bit l);
    pmc_in_t p;
    p.pixel_index = IDX_W'(idx);
    p.sample      = SAMPLE_BITS'(s);
    p.first_image = f;
    p.last_image  = l;
    return p;
  endfunction

  // one stack over a run of consecutive pixels from a random base, images interleaved
  task automatic queue_stack(input int npix, input int depth, input bit wide_idx);
    int base, k, i;
    int idxs[$];
    base = wide_idx ? $urandom_range(0, 4095 - npix) : $urandom_range(0, 60);
    for (k = 0; k < npix; k++) idxs = {idxs, base + k};
    for (i = 0; i < depth; i++)
      foreach (idxs[j]) begin
        int s;
        case ($urandom_range(0, 3))
          0: s = $urandom_range(0, 65535) - 32768;
          1: s = $urandom_range(0, 200) - 100;
          2: s = $urandom_range(0, 1) ? 32767 : -32768;
          default: s = int'(range_lo) + $urandom_range(0, 40) - 20;
        endcase
        queue_pixel(make_pixel(idxs[j], s, i == 0, i == depth - 1));
      end
  endtask

  int sent, ph;

  initial begin
    rst = 1'b1;
    pix_valid = 1'b0; pix = '0; res_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    avg_mode = 1'b0; range_lo = -16'sd32768; range_hi = 16'sd32767;
    mismatches = 0; quiet_tail = 1'b0; hold_off = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, both marks, re-open, max mode
    queue_pixel(make_pixel(0, -32768, 1, 1));
    queue_pixel(make_pixel(4095, 32767, 1, 1));
    queue_pixel(make_pixel(7, 5, 1, 0));
    queue_pixel(make_pixel(7, 9, 0, 0));
    queue_pixel(make_pixel(7, 9, 0, 0));
    queue_pixel(make_pixel(7, -3, 0, 1));
    queue_pixel(make_pixel(2730, 21845, 1, 0));
    queue_pixel(make_pixel(1365, -21846, 1, 1));
    queue_pixel(make_pixel(2730, -1, 0, 1));
    drain();

    // mean mode, narrow range, invalid held sample
    reg_write(REG_MODE, 32'd1);
    reg_write(REG_VALID_LOW, 32'hFFFF_FF9C);   // -100
    reg_write(REG_VALID_HIGH, 32'd100);
    queue_pixel(make_pixel(3, 500, 1, 0));
    queue_pixel(make_pixel(3, -700, 0, 1));
    queue_pixel(make_pixel(4, 7, 1, 0));
    queue_pixel(make_pixel(4, 8, 0, 0));
    queue_pixel(make_pixel(4, -4, 0, 1));
    drain();
    reg_write(REG_VALID_LOW, 32'h0000_8000);
    reg_write(REG_VALID_HIGH, 32'h0000_7FFF);
    for (int i = 0; i < 260; i++)   // count limit
      queue_pixel(make_pixel(9, 32767, i == 0, i == 259));
    drain();

    // empty range, mode switch mid-stack
    reg_write(REG_VALID_LOW, 32'd10);
    reg_write(REG_VALID_HIGH, 32'hFFFF_FFF6);
    queue_pixel(make_pixel(5, 42, 1, 1));
    drain();
    reg_write(REG_VALID_LOW, 32'h0000_8000);
    reg_write(REG_VALID_HIGH, 32'h0000_7FFF);
    queue_pixel(make_pixel(6, 10, 1, 0));
    queue_pixel(make_pixel(6, 20, 0, 0));
    drain();
    reg_write(REG_MODE, 32'd0);
    queue_pixel(make_pixel(6, 1, 0, 1));
    drain();

    // long receiver hold-off so the pipeline fills and stalls the input
    queue_stack(30, 3, 1'b1);
    hold_off = 1'b1;
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
    drain();

    // random phases with changing settings
    sent = 0;
    ph = 0;
    while (sent < 1150) begin
      int lo, hi, np, dp;
      reg_write(REG_MODE, $urandom_range(0, 1));
      lo = $urandom_range(0, 65535) - 32768;
      hi = $urandom_range(0, 65535) - 32768;
      if ($urandom_range(0, 3) != 0 && lo > hi) begin int t; t = lo; lo = hi; hi = t; end
      if (ph % 5 == 0) begin lo = -32768; hi = 32767; end
      reg_write(REG_VALID_LOW, lo);
      reg_write(REG_VALID_HIGH, hi);
      np = $urandom_range(1, 24);
      dp = $urandom_range(1, 8);
      if (sent > 900) quiet_tail = 1'b1;
      queue_stack(np, dp, ph % 2);
      sent += np * dp;
      ph++;
      drain();
    end

    if (mismatches == 0 && composite_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
